// ===== hw/rtl/hslc_pkg.sv =====
// hslc_pkg: shared constants, types and state encoding of the tag cache
// used by the controller, the datapath and the top level
package hslc_pkg;

  localparam int WAYS      = 8;
  localparam int MAX_SETS  = 256;
  localparam int ID_W      = 64;
  localparam int CNT_W     = 32;
  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NSETS_W   = 9;
  localparam int HASH_W    = 32;
  localparam int HASH_INIT = 5381;
  localparam int HASH_STEPS = 4;   // two id bytes per step
  localparam int MOD_STEPS  = 8;   // four hash bits per step
  localparam int STEP_W     = 3;
  localparam int META_W     = WAYS + WAYS * WAY_W;
  localparam int TAGROW_W   = WAYS * ID_W;
  localparam int OUT_W      = 1 + 8 + 3 + 1 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CMP
  } hslc_state_e;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_step;
    logic rd_en;
    logic commit;
  } hslc_cmd_t;

endpackage

// ===== hw/rtl/hslc_ram.sv =====
// hslc_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
module hslc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hslc_ctrl.sv =====
// hslc_ctrl: sequencer of one lookup (hash, modulo, set read, compare and update)
// depends on hslc_pkg
module hslc_ctrl
  import hslc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hslc_cmd_t cmd_o
);

  hslc_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic in_fire;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (step_q == STEP_W'(HASH_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_MOD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_MOD: begin
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_READ;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_HASH: cmd_o.hash_step = 1'b1;
      ST_MOD:  cmd_o.mod_step  = 1'b1;
      ST_READ: cmd_o.rd_en     = 1'b1;
      ST_CMP:  cmd_o.commit    = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_fire_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_HASH)
    else $error("accepted lookup did not start hashing");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit would overwrite an untaken result");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_q || state_q == ST_IDLE)
    else $error("input ready outside idle");

endmodule

// ===== hw/rtl/hslc_dp.sv =====
// hslc_dp: hash and modulo iterations, tag and recency stores, compare, lru update
// depends on hslc_pkg and hslc_ram
module hslc_dp
  import hslc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hslc_cmd_t          cmd_i,
  input  logic [ID_W-1:0]    id_i,
  input  logic [NSETS_W-1:0] num_sets_i,
  output logic               hit_o,
  output logic [SET_W-1:0]   set_o,
  output logic [WAY_W-1:0]   way_o,
  output logic               evicted_o,
  output logic [CNT_W-1:0]   hits_o,
  output logic [CNT_W-1:0]   misses_o,
  output logic [CNT_W-1:0]   evicts_o
);

  logic [ID_W-1:0]   id_q, src_q;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [SET_W-1:0]  set_q, set_d;
  logic [NSETS_W-1:0] n_eff;
  logic [MAX_SETS-1:0] row_vld_q;
  logic row_vld_rd_q;
  logic [TAGROW_W-1:0] tag_rd, tag_wr;
  logic [META_W-1:0]   meta_rd, meta_wr;
  logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, ev_cnt_q;
  logic res_hit_q, res_ev_q;
  logic [SET_W-1:0] res_set_q;
  logic [WAY_W-1:0] res_way_q;

  logic [WAYS-1:0]  vbits, vnew, zero_rank;
  logic [WAY_W-1:0] rank [WAYS];
  logic [WAY_W-1:0] rank_new [WAYS];
  logic [WAYS-1:0]  hit_vec;
  logic             hit;
  logic [WAY_W-1:0] hway, vway, way, old_rank;
  logic             ev;

  always_comb begin
    n_eff = num_sets_i;
    if (num_sets_i == '0) n_eff = NSETS_W'(1);
    else if (num_sets_i > NSETS_W'(MAX_SETS)) n_eff = NSETS_W'(MAX_SETS);
  end

  // h = h * 33 + byte, two bytes per step
  always_comb begin
    logic [HASH_W-1:0] h1;
    h1     = (hash_q << 5) + hash_q + HASH_W'(src_q[7:0]);
    hash_d = (h1 << 5) + h1 + HASH_W'(src_q[15:8]);
  end

  // restoring remainder, four bits of the hash per step
  always_comb begin
    logic [NSETS_W-1:0] r;
    r = NSETS_W'(set_q);
    for (int i = 0; i < 4; i++) begin
      r = {r[NSETS_W-2:0], hash_q[HASH_W-1-i]};
      if (r >= n_eff) r = r - n_eff;
    end
    set_d = r[SET_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= id_i;
      src_q  <= id_i;
      hash_q <= HASH_W'(HASH_INIT);
      set_q  <= '0;
    end else if (cmd_i.hash_step) begin
      src_q  <= src_q >> 16;
      hash_q <= hash_d;
    end else if (cmd_i.mod_step) begin
      hash_q <= hash_q << 4;
      set_q  <= set_d;
    end
  end

  hslc_ram #(.WIDTH(TAGROW_W), .DEPTH(MAX_SETS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && !hit),
    .waddr_i (set_q),
    .wdata_i (tag_wr),
    .re_i    (cmd_i.rd_en),
    .raddr_i (set_q),
    .rdata_o (tag_rd)
  );

  hslc_ram #(.WIDTH(META_W), .DEPTH(MAX_SETS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (set_q),
    .wdata_i (meta_wr),
    .re_i    (cmd_i.rd_en),
    .raddr_i (set_q),
    .rdata_o (meta_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      row_vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) row_vld_rd_q <= row_vld_q[set_q];
      if (cmd_i.commit) row_vld_q[set_q] <= 1'b1;
    end
  end

  // untouched rows read as all invalid with ranks in way order
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (row_vld_rd_q) begin
        vbits[w] = meta_rd[w];
        rank[w]  = meta_rd[WAYS + w*WAY_W +: WAY_W];
      end else begin
        vbits[w] = 1'b0;
        rank[w]  = WAY_W'(w);
      end
      hit_vec[w] = vbits[w] && (tag_rd[w*ID_W +: ID_W] == id_q);
    end
  end

  always_comb begin
    hway = '0;
    vway = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hway = WAY_W'(w);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rank[w] == WAY_W'(WAYS - 1)) vway = WAY_W'(w);
    end
    hit      = |hit_vec;
    way      = hit ? hway : vway;
    ev       = !hit && vbits[way];
    old_rank = rank[way];
    vnew     = vbits;
    vnew[way] = 1'b1;
    tag_wr   = tag_rd;
    tag_wr[way*ID_W +: ID_W] = id_q;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way) rank_new[w] = '0;
      else if (rank[w] < old_rank) rank_new[w] = rank[w] + 1'b1;
      else rank_new[w] = rank[w];
      zero_rank[w] = (rank_new[w] == '0);
      meta_wr[WAYS + w*WAY_W +: WAY_W] = rank_new[w];
    end
    meta_wr[WAYS-1:0] = vnew;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      ev_cnt_q   <= '0;
    end else if (cmd_i.commit) begin
      if (hit && hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
      if (!hit && miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
      if (ev && ev_cnt_q != '1) ev_cnt_q <= ev_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_q <= hit;
      res_ev_q  <= ev;
      res_set_q <= set_q;
      res_way_q <= way;
    end
  end

  assign hit_o     = res_hit_q;
  assign evicted_o = res_ev_q;
  assign set_o     = res_set_q;
  assign way_o     = res_way_q;
  assign hits_o    = hit_cnt_q;
  assign misses_o  = miss_cnt_q;
  assign evicts_o  = ev_cnt_q;

  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> NSETS_W'(set_q) < n_eff)
    else $error("set index not below set count");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> row_vld_q[$past(set_q)])
    else $error("updated row not marked as written");

  a_one_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot(zero_rank))
    else $error("updated ranks hold other than one most recent way");

endmodule

// ===== hw/rtl/hashed_set_lru_tag_cache.sv =====
// hashed_set_lru_tag_cache: top level, stream ports, apb register, controller and datapath
// depends on hslc_pkg, hslc_ctrl, hslc_dp
//
// Usage: each 64-bit id sent on the s_axis channel is looked up in a
// set-associative tag cache with true lru replacement per set. The set is
// the djb2 hash of the id's bytes modulo num_sets (apb register at 0x0,
// 0 acts as 1, above 256 saturates). One result per id leaves on m_axis:
// hit, set, way, eviction flag and three saturating counters.
// An id passes from transfer to the next possible transfer through
// 4 hash steps (two bytes each), 8 modulo steps (four bits each),
// one set read of the tag and recency rams, one compare and update step
// and one idle step; the compare and update step waits for a free output register.
// The result sits in an output register; if the receiver stalls, the next
// id is still taken and worked on, and its update waits until the held
// result has been taken.
// Reset clears the counters and per-set written flags, so there is no
// clearing pass; num_sets resets to 1.
module hashed_set_lru_tag_cache
  import hslc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [ID_W-1:0]        s_axis_tdata_i,  // [63:0] lookup_id
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] hit, [8:1] set_index, [11:9] way_index, [12] evicted,
  // [44:13] hits_so_far, [76:45] misses_so_far, [108:77] evictions_so_far
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  hslc_cmd_t cmd;
  logic [NSETS_W-1:0] num_sets_q;
  logic r_hit, r_ev;
  logic [SET_W-1:0] r_set;
  logic [WAY_W-1:0] r_way;
  logic [CNT_W-1:0] r_hits, r_misses, r_evicts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sets_q <= NSETS_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      num_sets_q <= pwdata[NSETS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? 32'(num_sets_q) : 32'h0;

  hslc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  hslc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .id_i       (s_axis_tdata_i),
    .num_sets_i (num_sets_q),
    .hit_o      (r_hit),
    .set_o      (r_set),
    .way_o      (r_way),
    .evicted_o  (r_ev),
    .hits_o     (r_hits),
    .misses_o   (r_misses),
    .evicts_o   (r_evicts)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({r_evicts, r_misses, r_hits, r_ev,
                                        3'(r_way), 8'(r_set), r_hit});

endmodule

// ===== test/hslc_checker.sv =====
`timescale 1ns / 100ps
// hslc_checker: watches the lookup, result and apb channels of the tag cache,
// predicts each result and compares it; depends on hslc_pkg
module hslc_checker
  import hslc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [ID_W-1:0]        s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [CNT_W-1:0] evictions;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] hits;
    logic             evicted;
    logic [2:0]       way;
    logic [7:0]       set;
    logic             hit;
  } lookup_res_t;

  localparam logic [2:0]       ADDR_NUM_SETS = 3'd0;
  localparam logic [CNT_W-1:0] CNT_TOP       = '1;

  logic [ID_W-1:0]  tags [MAX_SETS][WAYS];
  logic             valid [MAX_SETS][WAYS];
  logic [WAY_W-1:0] rank [MAX_SETS][WAYS];
  logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;
  logic [NSETS_W-1:0] num_sets;
  lookup_res_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] djb2(input logic [ID_W-1:0] id);
    logic [31:0] h;
    h = 32'd5381;
    for (int b = 0; b < 8; b++) h = h * 32'd33 + 32'(id[8*b +: 8]);
    return h;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_TOP) ? c : c + 1'b1;
  endfunction

  function automatic void make_recent(input int s, input int w);
    logic [WAY_W-1:0] old;
    old = rank[s][w];
    for (int k = 0; k < WAYS; k++)
      if (rank[s][k] < old) rank[s][k] = rank[s][k] + 1'b1;
    rank[s][w] = '0;
  endfunction

  function automatic lookup_res_t cache_lookup(input logic [ID_W-1:0] id);
    lookup_res_t r;
    int n, s, w;
    r = '0;
    n = (num_sets == 0) ? 1 : (num_sets > MAX_SETS) ? MAX_SETS : int'(num_sets);
    s = int'(djb2(id) % 32'(n));
    w = -1;
    for (int k = 0; k < WAYS; k++)
      if (w < 0 && valid[s][k] && tags[s][k] == id) w = k;
    if (w >= 0) begin
      r.hit = 1'b1;
      hit_cnt = sat_inc(hit_cnt);
    end else begin
      for (int k = 0; k < WAYS; k++)
        if (rank[s][k] == WAY_W'(WAYS - 1)) w = k;
      r.evicted = valid[s][w];
      if (r.evicted) evict_cnt = sat_inc(evict_cnt);
      tags[s][w] = id;
      valid[s][w] = 1'b1;
      miss_cnt = sat_inc(miss_cnt);
    end
    make_recent(s, w);
    r.set = 8'(s);
    r.way = 3'(w);
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evictions = evict_cnt;
    return r;
  endfunction

  task automatic report(input string what, input logic [CNT_W-1:0] exp_v,
                        input logic [CNT_W-1:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t e, a;
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SETS; s++)
        for (int w = 0; w < WAYS; w++) begin
          valid[s][w] = 1'b0;
          rank[s][w] = WAY_W'(w);
        end
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      num_sets = NSETS_W'(1);
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && paddr == ADDR_NUM_SETS)
        num_sets = pwdata[NSETS_W-1:0];
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_q.push_back(cache_lookup(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        a = lookup_res_t'(m_axis_tdata_i[OUT_W-1:0]);
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with no lookup waiting, actual %0h", $time, a);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (e.hit != a.hit) report("hit", CNT_W'(e.hit), CNT_W'(a.hit));
          if (e.set != a.set) report("set_index", CNT_W'(e.set), CNT_W'(a.set));
          if (e.way != a.way) report("way_index", CNT_W'(e.way), CNT_W'(a.way));
          if (e.evicted != a.evicted)
            report("evicted", CNT_W'(e.evicted), CNT_W'(a.evicted));
          if (e.hits != a.hits) report("hits_so_far", e.hits, a.hits);
          if (e.misses != a.misses) report("misses_so_far", e.misses, a.misses);
          if (e.evictions != a.evictions)
            report("evictions_so_far", e.evictions, a.evictions);
        end
      end
    end
  end

endmodule

// ===== test/tb_hashed_set_lru_tag_cache.sv =====
`timescale 1ns / 100ps
// tb_hashed_set_lru_tag_cache: stimulus and verdict for the tag cache
// depends on hslc_pkg, hashed_set_lru_tag_cache and hslc_checker
module tb_hashed_set_lru_tag_cache;
  import hslc_pkg::*;

  localparam int         STALL_LIMIT   = 3000;
  localparam logic [2:0] ADDR_NUM_SETS = 3'd0;
  localparam logic [2:0] ADDR_UNUSED   = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [ID_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int quiet_cycles = 0;
  bit calm;
  logic [ID_W-1:0] id_pool [48];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  hashed_set_lru_tag_cache DUT (.*);

  hslc_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= 21);
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) || psel)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_hashed_set_lru_tag_cache NOT OK");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_id(input logic [ID_W-1:0] id);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= id;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    s_axis_tvalid_i <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int phase_sets [10];
    logic [ID_W-1:0] id;
    phase_sets = '{256, 0, 300, 1, 7, 64, 511, 128, 3, 2};
    calm = 1'b0;
    for (int i = 0; i < 48; i++) id_pool[i] = rand_id();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one set after reset: extremes, a hit, then enough ids to evict
    send_id('0);
    send_id('1);
    send_id('0);
    send_id(64'hAAAA_AAAA_AAAA_AAAA);
    send_id(64'h5555_5555_5555_5555);
    send_id('1);
    for (int i = 0; i < 10; i++) send_id(64'(i + 1) << (6 * i));
    send_id('0);
    send_id(64'h8000_0000_0000_0001);
    drain();

    // writes to an unused address change nothing
    reg_write(ADDR_UNUSED, 32'd5);

    for (int p = 0; p < 10; p++) begin
      reg_write(ADDR_NUM_SETS, 32'(phase_sets[p]));
      calm = (p == 3);
      for (int i = 0; i < 8; i++) id_pool[$urandom_range(47)] = rand_id();
      for (int i = 0; i < 170; i++) begin
        if ($urandom_range(99) < 70) id = id_pool[$urandom_range(47)];
        else id = rand_id();
        send_id(id);
      end
      drain();
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0)
      $display("tb_hashed_set_lru_tag_cache OK");
    else
      $display("tb_hashed_set_lru_tag_cache NOT OK");
    $finish;
  end

endmodule
